// File: rtl/core/sae_pkg.sv
// ----------------------------------------------------------------------------
// sae_pkg
// Shared codes, field widths and parameter defaults of the sorted edge table.
// ----------------------------------------------------------------------------
package sae_pkg;

   // parameter defaults
   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_MAX_EDGES    = 4096;
   localparam int DEF_VALUE_BITS   = 32;

   // fixed field widths
   localparam int KIND_BITS      = 3;
   localparam int VERTEX_BITS    = 10;
   localparam int VALUE_IO_BITS  = 32;
   localparam int COUNT_BITS     = 11;
   localparam int HELD_BITS      = 13;
   localparam int STATUS_BITS    = 2;
   localparam int REQ_TDATA_BITS = 64;
   localparam int RSP_TDATA_BITS = 64;

   // request beat layout
   localparam int REQ_A_LO     = 0;
   localparam int REQ_B_LO     = REQ_A_LO + VERTEX_BITS;
   localparam int REQ_VALUE_LO = REQ_B_LO + VERTEX_BITS;
   localparam int REQ_TOTAL_LO = REQ_VALUE_LO + VALUE_IO_BITS;
   localparam int REQ_USED     = REQ_TOTAL_LO + COUNT_BITS;

   // response beat layout
   localparam int RSP_USED = STATUS_BITS + VALUE_IO_BITS + HELD_BITS + COUNT_BITS;

   // operation kinds
   localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_GET    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_SET    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_INCR   = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_ENUM   = 3'd5;

   // result status
   localparam logic [STATUS_BITS-1:0] STAT_DONE   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_MISS   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL   = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_FROZEN = 2'd3;

endpackage

// File: rtl/core/sorted_adjacency_edge_table.sv
// ----------------------------------------------------------------------------
// sorted_adjacency_edge_table
// Edge store with per-vertex chains sorted by second vertex, 32-bit values.
// ----------------------------------------------------------------------------
// One request at a time. A clear, an ignored kind, or an insert or enumerate
// on a frozen table goes straight to the response. Get, set, increment and
// insert read the chain head and then walk the chain, each chain step one
// registered read of the single-port edge memory, stopping at the first node
// whose second vertex is not below the one sought or at the chain's end; an
// insert that relinks a predecessor then writes that node. Enumerate reads the
// head of each vertex below the vertex count and numbers every edge on its
// chain. No clearing pass runs after reset or clear: a stale chain head is
// rejected by checking the owner vertex of the slot it names. A finished
// response waits in an output register; the next request is taken once the
// previous one has been handed to it.
module sorted_adjacency_edge_table #(
   parameter int MAX_VERTICES = sae_pkg::DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = sae_pkg::DEF_MAX_EDGES,
   parameter int VALUE_BITS   = sae_pkg::DEF_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: vertex_a, vertex_b, value, vertex_total from bit 0 up
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sae_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [sae_pkg::KIND_BITS-1:0]      req_tuser,  // kind
   // response: status, edge_value, edges_held, vertices_held from bit 0 up
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sae_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // oriented register
   input  logic                               csr_we,
   input  logic                               csr_wdata
);
   import sae_pkg::*;

   localparam int EDGE_AW = $clog2(MAX_EDGES);
   localparam int HEAD_AW = $clog2(MAX_VERTICES);
   localparam int LINK_W  = $clog2(MAX_EDGES + 1);
   localparam int WORD_W  = 2 * VERTEX_BITS + VALUE_BITS + LINK_W;

   logic               edge_we;
   logic [EDGE_AW-1:0] edge_addr;
   logic [WORD_W-1:0]  edge_wdata, edge_rdata;
   logic               head_we;
   logic [HEAD_AW-1:0] head_addr;
   logic [LINK_W-1:0]  head_wdata, head_rdata;

   // sequencer
   sae_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .VALUE_BITS   (VALUE_BITS),
      .EDGE_AW      (EDGE_AW),
      .HEAD_AW      (HEAD_AW),
      .LINK_W       (LINK_W),
      .WORD_W       (WORD_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .edge_we    (edge_we),
      .edge_addr  (edge_addr),
      .edge_wdata (edge_wdata),
      .edge_rdata (edge_rdata),
      .head_we    (head_we),
      .head_addr  (head_addr),
      .head_wdata (head_wdata),
      .head_rdata (head_rdata)
   );

   // edge slots: first vertex, second vertex, value, link
   sae_ram #(
      .DEPTH (MAX_EDGES),
      .WIDTH (WORD_W)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .addr  (edge_addr),
      .wdata (edge_wdata),
      .rdata (edge_rdata)
   );

   // chain heads per vertex
   sae_ram #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (LINK_W)
   ) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .addr  (head_addr),
      .wdata (head_wdata),
      .rdata (head_rdata)
   );

endmodule

// File: rtl/core/sae_ram.sv
// ----------------------------------------------------------------------------
// sae_ram
// Single-port synchronous memory, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module sae_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/sae_ctrl.sv
// ----------------------------------------------------------------------------
// sae_ctrl
// Operation sequencer: walks chains in the edge and head memories, inserts,
// updates values, numbers edges and holds the response beat.
// ----------------------------------------------------------------------------
module sae_ctrl #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096,
   parameter int VALUE_BITS   = 32,
   parameter int EDGE_AW      = $clog2(MAX_EDGES),
   parameter int HEAD_AW      = $clog2(MAX_VERTICES),
   parameter int LINK_W       = $clog2(MAX_EDGES + 1),
   parameter int WORD_W       = 2 * sae_pkg::VERTEX_BITS + VALUE_BITS + LINK_W
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sae_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   input  logic [sae_pkg::KIND_BITS-1:0]       req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sae_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // orientation register
   input  logic                                csr_we,
   input  logic                                csr_wdata,
   // edge memory
   output logic                                edge_we,
   output logic [EDGE_AW-1:0]                  edge_addr,
   output logic [WORD_W-1:0]                   edge_wdata,
   input  logic [WORD_W-1:0]                   edge_rdata,
   // head memory
   output logic                                head_we,
   output logic [HEAD_AW-1:0]                  head_addr,
   output logic [LINK_W-1:0]                   head_wdata,
   input  logic [LINK_W-1:0]                   head_rdata
);
   import sae_pkg::*;

   localparam int VB   = VERTEX_BITS;
   localparam int P_LO = 2 * VB;
   localparam int L_LO = P_LO + VALUE_BITS;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_EDGES);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_HREAD  = 4'd1;
   localparam logic [3:0] S_HCHK   = 4'd2;
   localparam logic [3:0] S_ECHK   = 4'd3;
   localparam logic [3:0] S_DECIDE = 4'd4;
   localparam logic [3:0] S_LINK   = 4'd5;
   localparam logic [3:0] S_EHEAD  = 4'd6;
   localparam logic [3:0] S_EHCHK  = 4'd7;
   localparam logic [3:0] S_EECHK  = 4'd8;
   localparam logic [3:0] S_ENEXT  = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   logic [3:0]              state_ff, state_in;
   logic [KIND_BITS-1:0]    kind_ff, kind_in;
   logic [VB-1:0]           a_ff, a_in, b_ff, b_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic                    oriented_ff, oriented_in;
   logic                    frozen_ff, frozen_in;
   logic [LINK_W-1:0]       total_ff, total_in;
   logic [COUNT_BITS-1:0]   vc_ff, vc_in;
   logic [LINK_W-1:0]       cur_ff, cur_in;
   logic [LINK_W-1:0]       first_ff, first_in;
   logic                    head_node_ff, head_node_in;
   logic                    found_ff, found_in;
   logic [WORD_W-1:0]       word_ff, word_in;
   logic                    pred_ok_ff, pred_ok_in;
   logic [EDGE_AW-1:0]      pred_ff, pred_in;
   logic [WORD_W-1:0]       pred_word_ff, pred_word_in;
   logic [COUNT_BITS-1:0]   ix_ff, ix_in;
   logic [LINK_W-1:0]       num_ff, num_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [VALUE_IO_BITS-1:0] result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic [VB-1:0]            rq_a, rq_b;
   logic [VALUE_IO_BITS-1:0] rq_value;
   logic [COUNT_BITS-1:0]    rq_total;
   logic                     swap;

   assign rq_a     = req_tdata[REQ_A_LO +: VB];
   assign rq_b     = req_tdata[REQ_B_LO +: VB];
   assign rq_value = req_tdata[REQ_VALUE_LO +: VALUE_IO_BITS];
   assign rq_total = req_tdata[REQ_TOTAL_LO +: COUNT_BITS];
   assign swap     = !oriented_ff && (rq_b < rq_a);

   // value conversions
   logic [63+VALUE_IO_BITS:0]       val_wide;
   logic [VALUE_BITS+31:0]          pay_wide;
   logic [VALUE_BITS+LINK_W-1:0]    num_wide;
   logic [HEAD_AW+COUNT_BITS-1:0]   a_wide, ix_wide;
   logic [HELD_BITS+LINK_W-1:0]     held_wide;

   assign val_wide  = {{64{rq_value[VALUE_IO_BITS-1]}}, rq_value};
   assign pay_wide  = {{32{word_ff[P_LO+VALUE_BITS-1]}}, word_ff[P_LO +: VALUE_BITS]};
   assign num_wide  = {{VALUE_BITS{1'b0}}, num_ff};
   assign a_wide    = {{(HEAD_AW+1){1'b0}}, a_ff};
   assign ix_wide   = {{HEAD_AW{1'b0}}, ix_ff};
   assign held_wide = {{HELD_BITS{1'b0}}, total_ff};

   // edge word fields on the read port
   logic [VB-1:0]     q_lo, q_hi;
   logic [LINK_W-1:0] q_link;
   logic              a_ok, b_ok, ix_ok;
   logic [VB-1:0]     ab_max;
   logic [COUNT_BITS-1:0] top;

   assign q_lo   = edge_rdata[0 +: VB];
   assign q_hi   = edge_rdata[VB +: VB];
   assign q_link = edge_rdata[L_LO +: LINK_W];
   assign a_ok   = int'(a_ff) < MAX_VERTICES;
   assign b_ok   = int'(b_ff) < MAX_VERTICES;
   assign ix_ok  = int'(ix_ff) < MAX_VERTICES;
   assign ab_max = (a_ff > b_ff) ? a_ff : b_ff;
   assign top    = {1'b0, ab_max} + 1'b1;

   // sequencer
   always_comb begin
      logic [WORD_W-1:0] wr_word;
      wr_word      = '0;
      state_in     = state_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      val_in       = val_ff;
      oriented_in  = csr_we ? csr_wdata : oriented_ff;
      frozen_in    = frozen_ff;
      total_in     = total_ff;
      vc_in        = vc_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      head_node_in = head_node_ff;
      found_in     = found_ff;
      word_in      = word_ff;
      pred_ok_in   = pred_ok_ff;
      pred_in      = pred_ff;
      pred_word_in = pred_word_ff;
      ix_in        = ix_ff;
      num_in       = num_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      edge_we      = 1'b0;
      edge_addr    = cur_ff[EDGE_AW-1:0];
      edge_wdata   = '0;
      head_we      = 1'b0;
      head_addr    = a_wide[HEAD_AW-1:0];
      head_wdata   = total_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in    = req_tuser;
               a_in       = swap ? rq_b : rq_a;
               b_in       = swap ? rq_a : rq_b;
               val_in     = val_wide[VALUE_BITS-1:0];
               found_in   = 1'b0;
               pred_ok_in = 1'b0;
               first_in   = NULL_LINK;
               status_in  = STAT_DONE;
               result_in  = '0;
               unique case (req_tuser)
                  KIND_CLEAR: begin
                     vc_in     = (int'(rq_total) > MAX_VERTICES) ?
                                 COUNT_BITS'(MAX_VERTICES) : rq_total;
                     total_in  = '0;
                     frozen_in = 1'b0;
                     state_in  = S_RESP;
                  end
                  KIND_INSERT: begin
                     if (frozen_ff) begin
                        status_in = STAT_FROZEN;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_HREAD;
                     end
                  end
                  KIND_GET, KIND_SET, KIND_INCR: begin
                     state_in = S_HREAD;
                  end
                  KIND_ENUM: begin
                     if (frozen_ff) begin
                        status_in = STAT_FROZEN;
                        state_in  = S_RESP;
                     end else begin
                        ix_in    = '0;
                        num_in   = '0;
                        state_in = S_EHEAD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // fetch the chain head of the first vertex
         S_HREAD: begin
            state_in = a_ok ? S_HCHK : S_DECIDE;
         end

         S_HCHK: begin
            if (head_rdata < total_ff) begin
               edge_addr    = head_rdata[EDGE_AW-1:0];
               cur_in       = head_rdata;
               head_node_in = 1'b1;
               state_in     = S_ECHK;
            end else begin
               state_in = S_DECIDE;
            end
         end

         // chain walk: a head left from before a clear fails the owner check
         S_ECHK: begin
            head_node_in = 1'b0;
            if (head_node_ff && (q_lo != a_ff)) begin
               state_in = S_DECIDE;
            end else begin
               if (head_node_ff) begin
                  first_in = cur_ff;
               end
               if (q_hi == b_ff) begin
                  found_in = 1'b1;
                  word_in  = edge_rdata;
                  state_in = S_DECIDE;
               end else if (q_hi < b_ff) begin
                  pred_ok_in   = 1'b1;
                  pred_in      = cur_ff[EDGE_AW-1:0];
                  pred_word_in = edge_rdata;
                  if (q_link < total_ff) begin
                     edge_addr = q_link[EDGE_AW-1:0];
                     cur_in    = q_link;
                  end else begin
                     state_in = S_DECIDE;
                  end
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            state_in = S_RESP;
            priority case (kind_ff)
               KIND_GET: begin
                  if (found_ff) begin
                     result_in = pay_wide[VALUE_IO_BITS-1:0];
                  end else begin
                     status_in = STAT_MISS;
                     result_in = '1;
                  end
               end
               KIND_SET, KIND_INCR: begin
                  if (found_ff) begin
                     wr_word = word_ff;
                     wr_word[P_LO +: VALUE_BITS] = (kind_ff == KIND_SET) ? val_ff :
                        word_ff[P_LO +: VALUE_BITS] + 1'b1;
                     edge_we    = 1'b1;
                     edge_wdata = wr_word;
                  end else begin
                     status_in = STAT_MISS;
                  end
               end
               KIND_INSERT: begin
                  if (found_ff) begin
                     status_in = STAT_MISS;
                  end else if (total_ff == NULL_LINK) begin
                     status_in = STAT_FULL;
                  end else if (!a_ok || !b_ok) begin
                     status_in = STAT_MISS;
                  end else begin
                     wr_word[0 +: VB]              = a_ff;
                     wr_word[VB +: VB]             = b_ff;
                     wr_word[P_LO +: VALUE_BITS]   = val_ff;
                     wr_word[L_LO +: LINK_W]       = pred_ok_ff ?
                        pred_word_ff[L_LO +: LINK_W] : first_ff;
                     edge_we    = 1'b1;
                     edge_addr  = total_ff[EDGE_AW-1:0];
                     edge_wdata = wr_word;
                     total_in   = total_ff + 1'b1;
                     vc_in      = (top > vc_ff) ? top : vc_ff;
                     cur_in     = total_ff;
                     if (pred_ok_ff) begin
                        state_in = S_LINK;
                     end else begin
                        head_we = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         // relink the predecessor to the new edge
         S_LINK: begin
            wr_word = pred_word_ff;
            wr_word[L_LO +: LINK_W] = cur_ff;
            edge_we    = 1'b1;
            edge_addr  = pred_ff;
            edge_wdata = wr_word;
            state_in   = S_RESP;
         end

         // enumerate: next vertex head
         S_EHEAD: begin
            head_addr = ix_wide[HEAD_AW-1:0];
            if ((ix_ff < vc_ff) && ix_ok) begin
               state_in = S_EHCHK;
            end else begin
               frozen_in = 1'b1;
               state_in  = S_RESP;
            end
         end

         S_EHCHK: begin
            if (head_rdata < total_ff) begin
               edge_addr    = head_rdata[EDGE_AW-1:0];
               cur_in       = head_rdata;
               head_node_in = 1'b1;
               state_in     = S_EECHK;
            end else begin
               ix_in    = ix_ff + 1'b1;
               state_in = S_EHEAD;
            end
         end

         // enumerate: number one edge
         S_EECHK: begin
            head_node_in = 1'b0;
            if (head_node_ff && ({1'b0, q_lo} != ix_ff)) begin
               ix_in    = ix_ff + 1'b1;
               state_in = S_EHEAD;
            end else begin
               wr_word = edge_rdata;
               wr_word[P_LO +: VALUE_BITS] = num_wide[VALUE_BITS-1:0];
               edge_we    = 1'b1;
               edge_wdata = wr_word;
               num_in     = num_ff + 1'b1;
               first_in   = q_link;
               state_in   = S_ENEXT;
            end
         end

         S_ENEXT: begin
            if (first_ff < total_ff) begin
               edge_addr = first_ff[EDGE_AW-1:0];
               cur_in    = first_ff;
               state_in  = S_EECHK;
            end else begin
               ix_in    = ix_ff + 1'b1;
               state_in = S_EHEAD;
            end
         end

         // hand the beat to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_TDATA_BITS-RSP_USED){1'b0}}, vc_ff,
                               held_wide[HELD_BITS-1:0], result_ff, status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oriented_ff  <= 1'b0;
         frozen_ff    <= 1'b0;
         total_ff     <= '0;
         vc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oriented_ff  <= oriented_in;
         frozen_ff    <= frozen_in;
         total_ff     <= total_in;
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      val_ff       <= val_in;
      cur_ff       <= cur_in;
      first_ff     <= first_in;
      head_node_ff <= head_node_in;
      found_ff     <= found_in;
      word_ff      <= word_in;
      pred_ok_ff   <= pred_ok_in;
      pred_ff      <= pred_in;
      pred_word_ff <= pred_word_in;
      ix_ff        <= ix_in;
      num_ff       <= num_in;
      status_ff    <= status_in;
      result_ff    <= result_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // writes land only on stored slots or the next free one
   a_edge_wr_range: assert property (@(posedge clock) disable iff (reset)
      edge_we |-> ({1'b0, edge_addr} <= total_ff))
      else $error("edge write beyond fill");

   // edge count stays within the store
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= NULL_LINK)
      else $error("edge count overflow");

   // a new chain head always names the slot being filled
   a_head_wr: assert property (@(posedge clock) disable iff (reset)
      head_we |-> (head_wdata == total_ff && edge_we))
      else $error("head write mismatch");

   // a frozen table's edge count changes only through a clear
   a_frozen_hold: assert property (@(posedge clock) disable iff (reset)
      $past(frozen_ff) && (total_ff != $past(total_ff)) |-> (total_ff == '0))
      else $error("insert while frozen");
`endif

endmodule
